### design/ktt_pkg.sv
// shared types and constants for the keyed timeout table
// no dependencies; imported by every module of the block

package ktt_pkg;

  localparam int unsigned MS_PER_SEC  = 1000;
  localparam int unsigned SWEEP_LIMIT = 16;
  localparam int unsigned THR_W       = 35;

  typedef enum logic [1:0] {
    FUNC_START  = 2'd0,
    FUNC_SWEEP  = 2'd1,
    FUNC_CANCEL = 2'd2,
    FUNC_CLEAR  = 2'd3
  } ktt_func_e;

  typedef enum logic [2:0] {
    ST_STARTED   = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_EXPIRED   = 3'd3,
    ST_NONE      = 3'd4,
    ST_REMOVED   = 3'd5,
    ST_NOT_FOUND = 3'd6,
    ST_CLEARED   = 3'd7
  } ktt_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_EVAL,
    S_DEC,
    S_FIN
  } ktt_state_e;

  typedef struct packed {
    logic [7:0]  id;
    logic [31:0] start_ms;
    logic [23:0] duration;
  } ktt_entry_t;

endpackage

### design/ktt_table.sv
// entry storage of the timeout table: one write port, one registered read port
// depends on ktt_pkg for the entry type

module ktt_table
  import ktt_pkg::*;
#(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  ktt_entry_t    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output ktt_entry_t    rdata_o
);

  ktt_entry_t mem_q [DEPTH];
  ktt_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/ktt_expiry.sv
// expiry compare unit: elapsed ms against (duration + grace + 1) * 1000
// depends on ktt_pkg for the entry type and constants

module ktt_expiry
  import ktt_pkg::*;
(
  input  logic        clk_i,
  input  ktt_entry_t  entry_i,
  input  logic [31:0] now_ms_i,
  input  logic [15:0] grace_i,
  output logic        expired_o
);

  logic [31:0]      diff_q;
  logic [THR_W-1:0] thr_q;
  logic [24:0]      allowed1;

  assign allowed1 = 25'(entry_i.duration) + 25'(grace_i) + 25'd1;

  always_ff @(posedge clk_i) begin
    diff_q <= now_ms_i - entry_i.start_ms;
    thr_q  <= THR_W'(allowed1) * THR_W'(MS_PER_SEC);
  end

  assign expired_o = THR_W'(diff_q) >= thr_q;

endmodule

### design/keyed_timeout_table_core.sv
// top level of the keyed timeout table: request sequencer, output register
// depends on ktt_pkg, ktt_table and ktt_expiry

// Start, sweep and cancel requests walk the stored entries one at a time
// through the single table read port and the expiry compare unit, each
// stored entry passing through the read, evaluate and decide states; a
// request also waits whenever a result cannot yet enter the output register,
// and a clear skips the walk. The table is compacted in place during the walk.
// Results leave through an output register, so the next request is taken
// while the final result still waits. The grace register may be written at
// any time the block is idle; cfg_ready_o is always high.

module keyed_timeout_table_core
  import ktt_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic [7:0]  compartment_id_i,
  input  logic [23:0] duration_sec_i,
  input  logic [31:0] now_ms_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [7:0]  result_id_o,
  output logic [4:0]  active_count_o,
  output logic        last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  ktt_state_e state_q, state_d;

  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] rd_q, rd_d;
  logic [CW-1:0] wr_q, wr_d;
  logic [CW-1:0] n_q, n_d;
  logic          pend_q, pend_d;
  logic          match_q, match_d;
  logic          found_q, found_d;
  logic [15:0]   grace_q;
  logic          out_valid_q, out_valid_d;

  ktt_func_e     func_q;
  logic [7:0]    id_q;
  logic [23:0]   dur_q;
  logic [31:0]   now_q;
  logic [7:0]    pend_id_q, pend_id_d;
  logic [CW-1:0] pend_cnt_q, pend_cnt_d;
  ktt_status_e   out_status_q;
  logic [7:0]    out_id_q;
  logic [4:0]    out_cnt_q;
  logic          out_last_q;

  logic          accept;
  logic          slot_free;
  logic          expired;
  logic          id_match;
  logic          remove;
  logic          stall;

  logic          emit;
  ktt_status_e   emit_status;
  logic [7:0]    emit_id;
  logic [CW-1:0] emit_cnt;
  logic          emit_last;

  logic          tbl_we;
  logic [AW-1:0] tbl_waddr;
  ktt_entry_t    tbl_wdata;
  logic          tbl_re;
  ktt_entry_t    tbl_rdata;

  ktt_table #(
    .DEPTH (MAX_ENTRIES),
    .AW    (AW)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .re_i    (tbl_re),
    .raddr_i (rd_q[AW-1:0]),
    .rdata_o (tbl_rdata)
  );

  ktt_expiry u_expiry (
    .clk_i     (clk_i),
    .entry_i   (tbl_rdata),
    .now_ms_i  (now_q),
    .grace_i   (grace_q),
    .expired_o (expired)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign slot_free   = !out_valid_q || out_ready_i;
  assign tbl_re      = (state_q == S_RD) && (rd_q != count_q);

  assign id_match = (tbl_rdata.id == id_q);
  assign remove   = ((func_q == FUNC_SWEEP) && expired && (int'(n_q) < SWEEP_LIMIT)) ||
                    ((func_q == FUNC_CANCEL) && id_match);
  assign stall    = remove && (func_q == FUNC_SWEEP) && pend_q && !slot_free;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = (ktt_func_e'(func_i) == FUNC_CLEAR) ? S_FIN : S_RD;
        end
      end
      S_RD:   state_d = (rd_q == count_q) ? S_FIN : S_EVAL;
      S_EVAL: state_d = S_DEC;
      S_DEC:  state_d = stall ? S_DEC : S_RD;
      S_FIN:  state_d = slot_free ? S_IDLE : S_FIN;
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    count_d     = count_q;
    rd_d        = rd_q;
    wr_d        = wr_q;
    n_d         = n_q;
    pend_d      = pend_q;
    pend_id_d   = pend_id_q;
    pend_cnt_d  = pend_cnt_q;
    match_d     = match_q;
    found_d     = found_q;
    emit        = 1'b0;
    emit_status = ST_NONE;
    emit_id     = 8'd0;
    emit_cnt    = count_q;
    emit_last   = 1'b0;
    tbl_we      = 1'b0;
    tbl_waddr   = wr_q[AW-1:0];
    tbl_wdata   = tbl_rdata;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          rd_d    = '0;
          wr_d    = '0;
          n_d     = '0;
          pend_d  = 1'b0;
          match_d = 1'b0;
          found_d = 1'b0;
        end
      end
      S_DEC: begin
        if (!stall) begin
          rd_d = rd_q + CW'(1);
          if (remove) begin
            n_d = n_q + CW'(1);
            if (func_q == FUNC_SWEEP) begin
              if (pend_q) begin
                emit        = 1'b1;
                emit_status = ST_EXPIRED;
                emit_id     = pend_id_q;
                emit_cnt    = pend_cnt_q;
              end
              pend_d     = 1'b1;
              pend_id_d  = tbl_rdata.id;
              pend_cnt_d = count_q - n_q - CW'(1);
            end else begin
              found_d = 1'b1;
            end
          end else begin
            tbl_we = 1'b1;
            wr_d   = wr_q + CW'(1);
            if ((func_q == FUNC_START) && id_match) begin
              match_d = 1'b1;
            end
          end
        end
      end
      S_FIN: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_last = 1'b1;
          unique case (func_q)
            FUNC_START: begin
              emit_id = id_q;
              if (match_q) begin
                emit_status = ST_DUPLICATE;
              end else if (count_q == CW'(MAX_ENTRIES)) begin
                emit_status = ST_FULL;
              end else begin
                emit_status        = ST_STARTED;
                tbl_we             = 1'b1;
                tbl_waddr          = count_q[AW-1:0];
                tbl_wdata.id       = id_q;
                tbl_wdata.start_ms = now_q;
                tbl_wdata.duration = dur_q;
                count_d            = count_q + CW'(1);
                emit_cnt           = count_q + CW'(1);
              end
            end
            FUNC_SWEEP: begin
              count_d = wr_q;
              if (pend_q) begin
                emit_status = ST_EXPIRED;
                emit_id     = pend_id_q;
                emit_cnt    = pend_cnt_q;
              end else begin
                emit_status = ST_NONE;
              end
            end
            FUNC_CANCEL: begin
              count_d     = wr_q;
              emit_id     = id_q;
              emit_cnt    = wr_q;
              emit_status = found_q ? ST_REMOVED : ST_NOT_FOUND;
            end
            FUNC_CLEAR: begin
              count_d     = '0;
              emit_cnt    = '0;
              emit_status = ST_CLEARED;
            end
            default: emit_status = ST_NONE;
          endcase
        end
      end
      default: ;
    endcase
    out_valid_d = emit ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      rd_q        <= '0;
      wr_q        <= '0;
      n_q         <= '0;
      pend_q      <= 1'b0;
      match_q     <= 1'b0;
      found_q     <= 1'b0;
      grace_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rd_q        <= rd_d;
      wr_q        <= wr_d;
      n_q         <= n_d;
      pend_q      <= pend_d;
      match_q     <= match_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        grace_q <= cfg_data_i;
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk_i) begin
    pend_id_q  <= pend_id_d;
    pend_cnt_q <= pend_cnt_d;
    if (accept) begin
      func_q <= ktt_func_e'(func_i);
      id_q   <= compartment_id_i;
      dur_q  <= duration_sec_i;
      now_q  <= now_ms_i;
    end
    if (emit) begin
      out_status_q <= emit_status;
      out_id_q     <= emit_id;
      out_cnt_q    <= 5'(emit_cnt);
      out_last_q   <= emit_last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign result_id_o    = out_id_q;
  assign active_count_o = out_cnt_q;
  assign last_o         = out_last_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_ENTRIES))
    else $error("entry count exceeds table depth");

  a_compact_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> (wr_q <= rd_q) && (rd_q <= count_q))
    else $error("compaction pointers out of order");

  a_sweep_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(n_q) <= SWEEP_LIMIT)
    else $error("sweep removed too many entries");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o)
    else $error("request taken while previous one still in progress");

  a_no_emit_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i && (state_q == S_DEC || state_q == S_FIN)) |-> !emit)
    else $error("result overwritten while output register is full");

endmodule

### dv/ktt_result_checker.sv
`timescale 1ns / 1ps
// response checker for keyed_timeout_table_core: keeps its own copy of the
// timeout table and grace register and compares each response; uses ktt_pkg

module ktt_result_checker
  import ktt_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  func_i,
  input  logic [7:0]  compartment_id_i,
  input  logic [23:0] duration_sec_i,
  input  logic [31:0] now_ms_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [2:0]  status_i,
  input  logic [7:0]  result_id_i,
  input  logic [4:0]  active_count_i,
  input  logic        last_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [15:0] cfg_data_i,
  output int          mismatch_count_o,
  output int          pending_count_o,
  output int          response_count_o
);

  typedef struct packed {
    ktt_status_e status;
    logic [7:0]  id;
    logic [4:0]  count;
    logic        last;
  } response_t;

  logic [7:0]  slot_id       [MAX_ENTRIES];
  logic [31:0] slot_start_ms [MAX_ENTRIES];
  logic [23:0] slot_duration [MAX_ENTRIES];
  int unsigned used_slots;
  logic [15:0] grace_sec;
  response_t   response_q[$];
  int          mismatches;
  int          responses;

  function automatic int find_slot(input logic [7:0] id);
    int hit;
    hit = -1;
    for (int unsigned k = 0; k < used_slots; k++) begin
      if (hit < 0 && slot_id[k] == id) hit = k;
    end
    return hit;
  endfunction

  task automatic remove_slot(input int unsigned idx);
    for (int unsigned j = idx; j + 1 < used_slots; j++) begin
      slot_id[j]       = slot_id[j + 1];
      slot_start_ms[j] = slot_start_ms[j + 1];
      slot_duration[j] = slot_duration[j + 1];
    end
    used_slots--;
  endtask

  task automatic push_response(input ktt_status_e st, input logic [7:0] id, input logic fin);
    response_q.push_back('{st, id, 5'(used_slots), fin});
  endtask

  task automatic table_update(input ktt_func_e f, input logic [7:0] id,
                              input logic [23:0] dur, input logic [31:0] now);
    int               hit;
    int unsigned      idx;
    int unsigned      removed;
    logic [31:0]      elapsed;
    logic [THR_W-1:0] allowed;
    logic [7:0]       gone;
    response_t        held;
    logic             have_held;
    hit       = -1;
    idx       = 0;
    removed   = 0;
    have_held = 1'b0;
    held      = '0;
    case (f)
      FUNC_START: begin
        hit = find_slot(id);
        if (hit >= 0) begin
          push_response(ST_DUPLICATE, id, 1'b1);
        end else if (used_slots >= MAX_ENTRIES) begin
          push_response(ST_FULL, id, 1'b1);
        end else begin
          slot_id[used_slots]       = id;
          slot_start_ms[used_slots] = now;
          slot_duration[used_slots] = dur;
          used_slots++;
          push_response(ST_STARTED, id, 1'b1);
        end
      end
      FUNC_SWEEP: begin
        while (idx < used_slots && removed < SWEEP_LIMIT) begin
          elapsed = (now - slot_start_ms[idx]) / MS_PER_SEC;
          allowed = THR_W'(slot_duration[idx]) + THR_W'(grace_sec);
          if (THR_W'(elapsed) > allowed) begin
            gone = slot_id[idx];
            remove_slot(idx);
            if (have_held) response_q.push_back(held);
            held      = '{ST_EXPIRED, gone, 5'(used_slots), 1'b0};
            have_held = 1'b1;
            removed++;
          end else begin
            idx++;
          end
        end
        if (have_held) begin
          held.last = 1'b1;
          response_q.push_back(held);
        end else begin
          push_response(ST_NONE, 8'd0, 1'b1);
        end
      end
      FUNC_CANCEL: begin
        hit = find_slot(id);
        if (hit >= 0) begin
          remove_slot(hit);
          push_response(ST_REMOVED, id, 1'b1);
        end else begin
          push_response(ST_NOT_FOUND, id, 1'b1);
        end
      end
      default: begin
        used_slots = 0;
        push_response(ST_CLEARED, 8'd0, 1'b1);
      end
    endcase
  endtask

  task automatic check_response();
    response_t want;
    responses++;
    if (response_q.size() == 0) begin
      $display("%0t: response with none expected: status %0d id %0d count %0d last %0d",
               $time, status_i, result_id_i, active_count_i, last_i);
      mismatches++;
    end else begin
      want = response_q.pop_front();
      if (status_i !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, status_i);
        mismatches++;
      end
      if (result_id_i !== want.id) begin
        $display("%0t: result_id expected %0d actual %0d", $time, want.id, result_id_i);
        mismatches++;
      end
      if (active_count_i !== want.count) begin
        $display("%0t: active_count expected %0d actual %0d",
                 $time, want.count, active_count_i);
        mismatches++;
      end
      if (last_i !== want.last) begin
        $display("%0t: last expected %0d actual %0d", $time, want.last, last_i);
        mismatches++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_slots = 0;
      grace_sec  = '0;
      mismatches = 0;
      responses  = 0;
      response_q.delete();
      mismatch_count_o <= 0;
      pending_count_o  <= 0;
      response_count_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) check_response();
      if (cfg_valid_i && cfg_ready_i) grace_sec = cfg_data_i;
      if (in_valid_i && in_ready_i) begin
        table_update(ktt_func_e'(func_i), compartment_id_i, duration_sec_i, now_ms_i);
      end
      mismatch_count_o <= mismatches;
      pending_count_o  <= response_q.size();
      response_count_o <= responses;
    end
  end

endmodule

### dv/keyed_timeout_table_core_tb.sv
`timescale 1ns / 1ps
// top of the keyed timeout table testbench: clock, reset, request and
// grace stimulus, output stalls and verdict; uses ktt_pkg, ktt_result_checker

module keyed_timeout_table_core_tb;
  import ktt_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 60;
  localparam int NUM_PHASES     = 5;
  localparam int PHASE_ITEMS    = 49;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  func_i;
  logic [7:0]  compartment_id_i;
  logic [23:0] duration_sec_i;
  logic [31:0] now_ms_i;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  status_o;
  logic [7:0]  result_id_o;
  logic [4:0]  active_count_o;
  logic        last_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i;

  int          mismatch_count;
  int          pending_count;
  int          response_count;
  int          burst_left;
  int          sent_count[4];
  int          idle_cycles;
  int          stall_left;
  int          calm_timer;
  logic        calm;
  logic [31:0] clock_ms;
  logic [15:0] grace_plan[NUM_PHASES];

  keyed_timeout_table_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .func_i          (func_i),
    .compartment_id_i(compartment_id_i),
    .duration_sec_i  (duration_sec_i),
    .now_ms_i        (now_ms_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .result_id_o     (result_id_o),
    .active_count_o  (active_count_o),
    .last_o          (last_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i)
  );

  ktt_result_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .func_i          (func_i),
    .compartment_id_i(compartment_id_i),
    .duration_sec_i  (duration_sec_i),
    .now_ms_i        (now_ms_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_i        (status_o),
    .result_id_i     (result_id_o),
    .active_count_i  (active_count_o),
    .last_i          (last_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_i     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .mismatch_count_o(mismatch_count),
    .pending_count_o (pending_count),
    .response_count_o(response_count)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // output stalls, with calm stretches of full throughput
  always @(posedge clk_i) begin
    calm_timer++;
    if (calm_timer >= 150) begin
      calm_timer = 0;
      calm = ($urandom_range(0, 3) == 0);
    end
    if (stall_left != 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      out_ready_i <= 1'b0;
      stall_left = $urandom_range(0, 6);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic send_req(input ktt_func_e f, input logic [7:0] id,
                          input logic [23:0] dur, input logic [31:0] stamp);
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 9) == 0) ? 40 : $urandom_range(1, 8);
    end
    in_valid_i       <= 1'b1;
    func_i           <= f;
    compartment_id_i <= id;
    duration_sec_i   <= dur;
    now_ms_i         <= stamp;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent_count[int'(f)]++;
    burst_left--;
    if (burst_left == 0) in_valid_i <= 1'b0;
  endtask

  // drop valid, wait for every response, then let the block go quiet
  task automatic settle();
    if (burst_left != 0) begin
      in_valid_i <= 1'b0;
      burst_left = 0;
    end
    repeat (2) @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_grace(input logic [15:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_request();
    int          pick;
    logic [1:0]  f;
    logic [7:0]  id;
    logic [23:0] dur;
    logic [31:0] stamp;
    pick = $urandom_range(0, 99);
    id   = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 19));
    dur  = ($urandom_range(0, 9) == 0) ? 24'($urandom) : 24'($urandom_range(0, 12));
    if ($urandom_range(0, 29) == 0) clock_ms = clock_ms + $urandom;
    else clock_ms = clock_ms + $urandom_range(0, 3000);
    stamp = clock_ms;
    if (pick < 40) f = FUNC_START;
    else if (pick < 70) f = FUNC_SWEEP;
    else if (pick < 87) f = FUNC_CANCEL;
    else if (pick < 92) f = FUNC_CLEAR;
    else begin
      f     = 2'($urandom);
      id    = 8'($urandom);
      dur   = 24'($urandom);
      stamp = $urandom;
    end
    send_req(ktt_func_e'(f), id, dur, stamp);
  endtask

  initial begin
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    func_i           = FUNC_START;
    compartment_id_i = '0;
    duration_sec_i   = '0;
    now_ms_i         = '0;
    cfg_valid_i      = 1'b0;
    cfg_data_i       = '0;
    burst_left       = 0;
    idle_cycles      = 0;
    stall_left       = 0;
    calm_timer       = 0;
    calm             = 1'b0;
    clock_ms         = '0;
    for (int k = 0; k < 4; k++) sent_count[k] = 0;
    grace_plan[0] = 16'hFFFF;
    grace_plan[1] = 16'($urandom_range(1, 20));
    grace_plan[2] = 16'd0;
    grace_plan[3] = 16'($urandom);
    grace_plan[4] = 16'd2;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // empty table, id and time extremes, duplicates, full table, sweep
    send_req(FUNC_SWEEP, 8'd0, 24'd0, 32'd0);
    send_req(FUNC_CANCEL, 8'd9, 24'd0, 32'd0);
    send_req(FUNC_CLEAR, 8'd0, 24'd0, 32'd0);
    send_req(FUNC_START, 8'd0, 24'd0, 32'd0);
    send_req(FUNC_START, 8'hFF, 24'hFFFFFF, 32'hFFFFFFFF);
    send_req(FUNC_START, 8'd0, 24'd3, 32'd100);
    send_req(FUNC_CANCEL, 8'hFF, 24'd0, 32'd0);
    send_req(FUNC_START, 8'hFF, 24'hFFFFFF, 32'hFFFFFFFF);
    for (int k = 1; k <= 14; k++) send_req(FUNC_START, 8'(k), 24'(k), 32'd0);
    send_req(FUNC_START, 8'd200, 24'd1, 32'd0);
    send_req(FUNC_START, 8'd5, 24'd1, 32'd0);
    send_req(FUNC_SWEEP, 8'd0, 24'd0, 32'd8500);
    send_req(FUNC_CLEAR, 8'd0, 24'd0, 32'd0);

    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      write_grace(grace_plan[p]);
      if (p == 2) clock_ms = 32'hFFFF8000 + $urandom_range(0, 30000);
      repeat (PHASE_ITEMS) random_request();
    end
    settle();

    $display("Sent %0d requests: %0d start, %0d sweep, %0d cancel, %0d clear",
             sent_count[0] + sent_count[1] + sent_count[2] + sent_count[3],
             sent_count[0], sent_count[1], sent_count[2], sent_count[3]);
    $display("Checked %0d responses across %0d grace settings, 0 and 65535 included",
             response_count, NUM_PHASES + 1);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### filelist.f
design/ktt_pkg.sv
design/ktt_table.sv
design/ktt_expiry.sv
design/keyed_timeout_table_core.sv
dv/ktt_result_checker.sv
dv/keyed_timeout_table_core_tb.sv
